@@ design/knn_pkg.sv @@
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants of the nearest-neighbor classifier.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int FEAT_W       = 16;
    localparam int MAX_FEATURES = 8;
    localparam int LABEL_W      = 4;
    localparam int INDEX_W      = 8;
    localparam int DIST_W       = 37;
    localparam int SQ_W         = 32;
    localparam int VOTE_W       = 5;
    localparam int CFG_W        = 9;

    localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RST = 9'd256;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // register word index on the config port
    typedef enum logic {
        REG_ENTRIES_IN_USE = 1'b0
    } reg_index_t;

    typedef logic signed [FEAT_W-1:0] feat_t;

    typedef struct packed {
        logic                       kind;
        logic [INDEX_W-1:0]         entry_index;
        logic [LABEL_W-1:0]         entry_label;
        logic signed [FEAT_W-1:0]   feature_0;
        logic signed [FEAT_W-1:0]   feature_1;
        logic signed [FEAT_W-1:0]   feature_2;
        logic signed [FEAT_W-1:0]   feature_3;
        logic signed [FEAT_W-1:0]   feature_4;
        logic signed [FEAT_W-1:0]   feature_5;
        logic signed [FEAT_W-1:0]   feature_6;
        logic signed [FEAT_W-1:0]   feature_7;
    } in_item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] predicted_label;
        logic [VOTE_W-1:0]  vote_count;
    } out_item_t;

    // decoded item handed from front to back
    typedef struct packed {
        logic                       is_query;
        logic                       do_load;
        logic [INDEX_W-1:0]         index;
        logic [LABEL_W-1:0]         label;
        feat_t [MAX_FEATURES-1:0]   vec;
    } cmd_t;

endpackage

@@ design/knn_ram.sv @@
// ----------------------------------------------------------------------------
// knn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module knn_ram #(
    parameter int WIDTH  = 132,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/knn_front.sv @@
// ----------------------------------------------------------------------------
// knn_front
// Accepts items, decodes load/query and queues them for the back end.
// ----------------------------------------------------------------------------
module knn_front #(
    parameter int ENTRIES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  knn_pkg::in_item_t item,
    input  logic              push,
    output logic              full,
    output knn_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_pop
);

    localparam int DEPTH = 2;

    knn_pkg::cmd_t q_reg [DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    knn_pkg::cmd_t dec;
    logic          wr;

    always_comb
    begin
        dec.is_query = (item.kind == knn_pkg::KIND_QUERY);
        dec.do_load  = (item.kind == knn_pkg::KIND_LOAD) &&
                       (32'(item.entry_index) < ENTRIES);
        dec.index    = item.entry_index;
        dec.label    = item.entry_label;
        dec.vec[0]   = item.feature_0;
        dec.vec[1]   = item.feature_1;
        dec.vec[2]   = item.feature_2;
        dec.vec[3]   = item.feature_3;
        dec.vec[4]   = item.feature_4;
        dec.vec[5]   = item.feature_5;
        dec.vec[6]   = item.feature_6;
        dec.vec[7]   = item.feature_7;
    end

    assign full      = (cnt_reg == 2'(DEPTH));
    assign wr        = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(wr) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(DEPTH))
        else $error("front queue overfilled");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("front queue popped while empty");
`endif

endmodule

@@ design/knn_back.sv @@
// ----------------------------------------------------------------------------
// knn_back
// Runs loads into the training RAM and walks it for queries; holds the result.
// ----------------------------------------------------------------------------
module knn_back #(
    parameter int ENTRIES   = 256,
    parameter int NEIGHBORS = 5,
    parameter int FEATURES  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  knn_pkg::cmd_t                 cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  logic [knn_pkg::CFG_W-1:0]     entries_in_use,
    output knn_pkg::out_item_t            result,
    output logic                          empty,
    input  logic                          pop
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int NW    = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int VEC_W = FEATURES * knn_pkg::FEAT_W;
    localparam int RAM_W = VEC_W + knn_pkg::LABEL_W;
    localparam int SUM_W = knn_pkg::SQ_W + ((FEATURES > 1) ? $clog2(FEATURES) : 0);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_VOTE,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  iss_reg, iss_next;
    logic [CW-1:0]                  lim_reg, lim_next;
    logic [NW-1:0]                  vote_idx_reg, vote_idx_next;
    logic [knn_pkg::VOTE_W-1:0]     best_votes_reg, best_votes_next;
    logic [knn_pkg::LABEL_W-1:0]    best_label_reg, best_label_next;
    knn_pkg::out_item_t             res_reg, res_next;
    logic                           res_vld_reg, res_vld_next;

    // datapath
    knn_pkg::feat_t [FEATURES-1:0]  q_vec_reg;
    logic [knn_pkg::DIST_W-1:0]     dist_reg [NEIGHBORS];
    logic [knn_pkg::LABEL_W-1:0]    lbl_reg [NEIGHBORS];
    logic [NW-1:0]                  far_idx_reg, far_idx_next;
    logic [knn_pkg::DIST_W-1:0]     far_val_reg, far_val_next;
    logic                           stall_reg, stall_next;
    logic                           a_vld_reg, b_vld_reg, c_vld_reg;
    logic [knn_pkg::SQ_W-1:0]       b_sq_reg [FEATURES];
    logic [knn_pkg::LABEL_W-1:0]    b_lbl_reg, c_lbl_reg;
    logic [SUM_W-1:0]               c_sum_reg, c_sum;
    logic [knn_pkg::SQ_W-1:0]       sq [FEATURES];

    logic                           start, adv, issue, upd, ram_we;
    logic [RAM_W-1:0]               ram_q, ram_wdata;
    logic [15:0]                    idx_wide;
    logic [knn_pkg::VOTE_W-1:0]     votes;
    logic [NEIGHBORS-1:0]           is_far;

    assign start     = (state_reg == S_IDLE) && cmd_valid && cmd.is_query;
    assign ram_we    = (state_reg == S_IDLE) && cmd_valid && !cmd.is_query && cmd.do_load;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign adv       = !stall_reg;
    assign issue     = (state_reg == S_SEARCH) && adv && (iss_reg < lim_reg);
    assign idx_wide  = {8'd0, cmd.index};
    assign ram_wdata = {cmd.label, cmd.vec[FEATURES-1:0]};
    assign upd       = adv && c_vld_reg &&
                       (knn_pkg::DIST_W'(c_sum_reg) < far_val_reg);

    knn_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_wide[AW-1:0]),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (iss_reg[AW-1:0]),
        .rdata (ram_q)
    );

    // squares of the feature differences, 17-bit diff fits 32-bit square
    always_comb
    begin
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        for (int f = 0; f < FEATURES; f++)
        begin
            diff  = 17'($signed(ram_q[f*knn_pkg::FEAT_W +: knn_pkg::FEAT_W]))
                    - 17'($signed(q_vec_reg[f]));
            prod  = diff * diff;
            sq[f] = prod[knn_pkg::SQ_W-1:0];
        end
    end

    always_comb
    begin
        c_sum = '0;
        for (int f = 0; f < FEATURES; f++)
        begin
            c_sum = c_sum + SUM_W'(b_sq_reg[f]);
        end
    end

    // farthest slot: strictly above all lower slots, not below any higher one
    always_comb
    begin
        far_idx_next = '0;
        far_val_next = '0;
        for (int s = 0; s < NEIGHBORS; s++)
        begin
            is_far[s] = 1'b1;
            for (int t = 0; t < NEIGHBORS; t++)
            begin
                if (t < s && !(dist_reg[s] > dist_reg[t]))
                begin
                    is_far[s] = 1'b0;
                end
                if (t > s && dist_reg[s] < dist_reg[t])
                begin
                    is_far[s] = 1'b0;
                end
            end
            if (is_far[s])
            begin
                far_idx_next = far_idx_next | NW'(s);
                far_val_next = far_val_next | dist_reg[s];
            end
        end
    end

    assign stall_next = start || upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NEIGHBORS; s++)
            begin
                dist_reg[s] <= '1;
                lbl_reg[s]  <= '0;
            end
            stall_reg   <= 1'b0;
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            far_idx_reg <= '0;
            far_val_reg <= '1;
        end
        else
        begin
            stall_reg   <= stall_next;
            far_idx_reg <= far_idx_next;
            far_val_reg <= far_val_next;
            if (start)
            begin
                for (int s = 0; s < NEIGHBORS; s++)
                begin
                    dist_reg[s] <= '1;
                    lbl_reg[s]  <= '0;
                end
            end
            else if (upd)
            begin
                dist_reg[far_idx_reg] <= knn_pkg::DIST_W'(c_sum_reg);
                lbl_reg[far_idx_reg]  <= c_lbl_reg;
            end
            if (adv)
            begin
                a_vld_reg <= issue;
                b_vld_reg <= a_vld_reg;
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_vec_reg <= cmd.vec[FEATURES-1:0];
        end
        if (adv)
        begin
            for (int f = 0; f < FEATURES; f++)
            begin
                b_sq_reg[f] <= sq[f];
            end
            b_lbl_reg <= ram_q[RAM_W-1 -: knn_pkg::LABEL_W];
            c_lbl_reg <= b_lbl_reg;
            c_sum_reg <= c_sum;
        end
    end

    // votes for the slot under inspection, itself included
    always_comb
    begin
        votes = '0;
        for (int t = 0; t < NEIGHBORS; t++)
        begin
            votes = votes + knn_pkg::VOTE_W'(lbl_reg[t] == lbl_reg[vote_idx_reg]);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        iss_next        = iss_reg;
        lim_next        = lim_reg;
        vote_idx_next   = vote_idx_reg;
        best_votes_next = best_votes_reg;
        best_label_next = best_label_reg;
        res_next        = res_reg;
        res_vld_next    = res_vld_reg && !pop;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    iss_next   = '0;
                    lim_next   = (32'(entries_in_use) > ENTRIES) ? CW'(ENTRIES)
                                                                 : CW'(entries_in_use);
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (issue)
                begin
                    iss_next = iss_reg + CW'(1);
                end
                if ((iss_reg == lim_reg) && !a_vld_reg && !b_vld_reg &&
                    !c_vld_reg && adv)
                begin
                    vote_idx_next   = '0;
                    best_votes_next = knn_pkg::VOTE_W'(1);
                    best_label_next = lbl_reg[0];
                    state_next      = S_VOTE;
                end
            end
            S_VOTE:
            begin
                if (votes > best_votes_reg)
                begin
                    best_votes_next = votes;
                    best_label_next = lbl_reg[vote_idx_reg];
                end
                vote_idx_next = vote_idx_reg + NW'(1);
                if (vote_idx_reg == NW'(NEIGHBORS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_vld_reg || pop)
                begin
                    res_next.predicted_label = best_label_reg;
                    res_next.vote_count      = best_votes_reg;
                    res_vld_next             = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_reg        <= '0;
            lim_reg        <= '0;
            vote_idx_reg   <= '0;
            best_votes_reg <= '0;
            best_label_reg <= '0;
            res_reg        <= '0;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            lim_reg        <= lim_next;
            vote_idx_reg   <= vote_idx_next;
            best_votes_reg <= best_votes_next;
            best_label_reg <= best_label_next;
            res_reg        <= res_next;
            res_vld_reg    <= res_vld_next;
        end
    end

    assign result = res_reg;
    assign empty  = !res_vld_reg;

`ifndef SYNTHESIS
    a_stall_one: assert property (@(posedge clk) disable iff (!rst_n)
        stall_reg && (state_reg == S_SEARCH) |=> !stall_reg)
        else $error("replacement stall longer than one cycle");
    a_vote_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VOTE) |-> !a_vld_reg && !b_vld_reg && !c_vld_reg)
        else $error("vote started with entries in flight");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !pop |=> res_vld_reg && $stable(res_reg))
        else $error("waiting result overwritten");
`endif

endmodule

@@ design/knn_majority_classifier.sv @@
// Load item: taken from the queue and written to the training RAM, no result.
// Query: reads entries_in_use entries (at most ENTRIES), one training-RAM read
// per cycle except while a query start or a slot replacement stalls it. One
// query runs at a time; up to two items queue in front of it. Reset (async,
// rst_n low): queues empty, entries_in_use = 256; the training RAM keeps no
// reset and must be loaded first by the user; the block does not enforce it.
// ----------------------------------------------------------------------------
// knn_majority_classifier
// k-nearest-neighbor classifier: squared Euclidean distance, majority vote.
// ----------------------------------------------------------------------------
module knn_majority_classifier #(
    parameter int ENTRIES   = 256,
    parameter int NEIGHBORS = 5,
    parameter int FEATURES  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // item side
    input  knn_pkg::in_item_t   item,
    input  logic                push,
    output logic                full,
    // result side
    output knn_pkg::out_item_t  result,
    output logic                empty,
    input  logic                pop,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [knn_pkg::CFG_W-1:0] eiu_reg, eiu_next;
    knn_pkg::cmd_t             cmd;
    logic                      cmd_valid;
    logic                      cmd_pop;
    knn_pkg::reg_index_t       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = knn_pkg::reg_index_t'(paddr[2]);

    // register file: writes land on the access phase
    always_comb
    begin
        eiu_next = eiu_reg;
        prdata   = '0;
        unique case (reg_sel)
            knn_pkg::REG_ENTRIES_IN_USE:
            begin
                prdata = 32'(eiu_reg);
                if (psel && penable && pwrite)
                begin
                    eiu_next = pwdata[knn_pkg::CFG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg <= knn_pkg::ENTRIES_IN_USE_RST;
        end
        else
        begin
            eiu_reg <= eiu_next;
        end
    end

    // front: accept and decode items into a short queue
    knn_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // back: RAM writes, neighbor search, vote and the result register
    knn_back #(
        .ENTRIES   (ENTRIES),
        .NEIGHBORS (NEIGHBORS),
        .FEATURES  (FEATURES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .entries_in_use (eiu_reg),
        .result         (result),
        .empty          (empty),
        .pop            (pop)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the nearest-neighbor classifier. Loads fill the training store,
// queries are checked against an in-bench k-NN vote predictor, over several
// entries_in_use settings, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STORE_DEPTH = 256;
    localparam int SLOTS       = 5;
    localparam int N_FEAT      = 8;
    localparam int ITEM_GOAL   = 1850;
    localparam int SETTLE_CYC  = 400;   // a full-store query plus margin

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    knn_pkg::in_item_t  item = '0;
    logic               push = 1'b0;
    logic               full;
    knn_pkg::out_item_t result;
    logic               empty;
    logic               pop = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // shadow of the block state, kept in step with accepted items
    logic signed [15:0] store_vec [STORE_DEPTH][N_FEAT];
    logic [3:0]         store_label [STORE_DEPTH];
    logic [8:0]         search_count = 9'd256;

    knn_pkg::in_item_t  item_backlog[$];     // waiting to be offered
    knn_pkg::out_item_t expected_votes[$];   // predicted, not yet popped
    int                 mismatches = 0;
    int                 items_queued = 0;
    bit                 calm = 1'b0;         // no idling on either side
    bit                 long_stall_go = 1'b0;
    bit                 long_stall_done = 1'b0;
    int                 stall_left = 0;

    knn_majority_classifier DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic void feats_of(input knn_pkg::in_item_t it,
                                     output logic signed [15:0] f [N_FEAT]);
        f[0] = it.feature_0; f[1] = it.feature_1; f[2] = it.feature_2; f[3] = it.feature_3;
        f[4] = it.feature_4; f[5] = it.feature_5; f[6] = it.feature_6; f[7] = it.feature_7;
    endfunction

    // squared Euclidean distance to every searched entry, keep SLOTS nearest,
    // then majority vote with the first strict winner
    function automatic knn_pkg::out_item_t vote_of_query(input knn_pkg::in_item_t it);
        logic signed [15:0] q [N_FEAT];
        logic [36:0]        slot_dist [SLOTS];
        logic [3:0]         slot_label [SLOTS];
        logic [36:0]        sq_sum;
        longint             diff;
        int                 count;
        int                 far;
        int                 votes;
        int                 best_votes;
        logic [3:0]         best_label;
        knn_pkg::out_item_t r;
        feats_of(it, q);
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_dist[s]  = '1;
            slot_label[s] = '0;
        end
        count = (search_count > STORE_DEPTH) ? STORE_DEPTH : search_count;
        for (int e = 0; e < count; e++)
        begin
            sq_sum = '0;
            for (int f = 0; f < N_FEAT; f++)
            begin
                diff   = longint'(store_vec[e][f]) - longint'(q[f]);
                sq_sum = sq_sum + 37'(diff * diff);
            end
            far = 0;
            for (int s = 1; s < SLOTS; s++)
                if (slot_dist[s] > slot_dist[far])
                    far = s;
            if (sq_sum < slot_dist[far])
            begin
                slot_dist[far]  = sq_sum;
                slot_label[far] = store_label[e];
            end
        end
        best_votes = 1;
        best_label = slot_label[0];
        for (int s = 0; s < SLOTS; s++)
        begin
            votes = 1;
            for (int t = 0; t < SLOTS; t++)
                if (t != s && slot_label[t] == slot_label[s])
                    votes++;
            if (votes > best_votes)
            begin
                best_votes = votes;
                best_label = slot_label[s];
            end
        end
        r.predicted_label = best_label;
        r.vote_count      = 5'(best_votes);
        return r;
    endfunction

    // driver: offer backlog items, update the shadow on acceptance
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            if (item.kind == knn_pkg::KIND_LOAD)
            begin
                feats_of(item, store_vec[item.entry_index]);
                store_label[item.entry_index] = item.entry_label;
            end
            else
                expected_votes.push_back(vote_of_query(item));
            void'(item_backlog.pop_front());
        end
        if (rst_n && item_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= 16))
        begin
            push <= 1'b1;
            item <= item_backlog[0];
        end
        else
            push <= 1'b0;
    end

    // one-time long receiver hold-off, counted in cycles
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (long_stall_go && !long_stall_done)
        begin
            stall_left      <= 2000;
            long_stall_done <= 1'b1;
        end
    end

    // monitor: pop results, check against the oldest prediction;
    // the long hold-off lets the block fill and raise full
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_votes.size() == 0)
                report("unexpected result, label", result.predicted_label, -1);
            else
            begin
                if (result.predicted_label !== expected_votes[0].predicted_label)
                    report("predicted_label", result.predicted_label,
                           expected_votes[0].predicted_label);
                if (result.vote_count !== expected_votes[0].vote_count)
                    report("vote_count", result.vote_count, expected_votes[0].vote_count);
                void'(expected_votes.pop_front());
            end
        end
        if (!rst_n || stall_left > 0 || (long_stall_go && !long_stall_done))
            pop <= 1'b0;
        else
            pop <= calm || ($urandom_range(0, 99) >= 16);
    end

    task automatic write_entries_in_use(input int value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {knn_pkg::REG_ENTRIES_IN_USE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        search_count = 9'(value);
    endtask

    // all offered, all results back, then let trailing loads drain
    task automatic wait_quiet();
        wait (item_backlog.size() == 0 && expected_votes.size() == 0);
        @(posedge clk);
        wait (!push && expected_votes.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic int rand_feat(input int label);
        case ($urandom_range(0, 5))
            0, 1:    return $urandom_range(0, 65535);
            2:       return $urandom_range(0, 1) ? 32767 : -32768;
            default: return label * 1500 - 8000 + $urandom_range(0, 1200);
        endcase
    endfunction

    function automatic knn_pkg::in_item_t make_item(input logic kind, input int idx,
                                                    input int label, input int fv);
        knn_pkg::in_item_t it;
        int                v [N_FEAT];
        for (int f = 0; f < N_FEAT; f++)
            v[f] = (fv == 1) ? rand_feat(label) : fv;
        it = '0;
        it.kind        = kind;
        it.entry_index = 8'(idx);
        it.entry_label = 4'(label);
        it.feature_0 = 16'(v[0]); it.feature_1 = 16'(v[1]);
        it.feature_2 = 16'(v[2]); it.feature_3 = 16'(v[3]);
        it.feature_4 = 16'(v[4]); it.feature_5 = 16'(v[5]);
        it.feature_6 = 16'(v[6]); it.feature_7 = 16'(v[7]);
        return it;
    endfunction

    task automatic queue_item(input knn_pkg::in_item_t it);
        item_backlog.push_back(it);
        items_queued++;
    endtask

    function automatic int rand_label();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    endfunction

    initial
    begin
        int cfg;
        int n_items;
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero entries: all slots keep label 0, full vote
        write_entries_in_use(0);
        queue_item(make_item(knn_pkg::KIND_QUERY, 255, 15, -32768));
        wait_quiet();

        // distinct labels, extreme vectors: no repeated label
        write_entries_in_use(5);
        queue_item(make_item(knn_pkg::KIND_LOAD, 0, 15, 32767));
        queue_item(make_item(knn_pkg::KIND_LOAD, 1, 1, -32768));
        queue_item(make_item(knn_pkg::KIND_LOAD, 2, 2, 0));
        queue_item(make_item(knn_pkg::KIND_LOAD, 3, 3, 32767));
        queue_item(make_item(knn_pkg::KIND_LOAD, 4, 0, -1));
        queue_item(make_item(knn_pkg::KIND_LOAD, 255, 15, -32768));
        queue_item(make_item(knn_pkg::KIND_QUERY, 0, 0, 32767));
        queue_item(make_item(knn_pkg::KIND_QUERY, 255, 15, -32768));
        queue_item(make_item(knn_pkg::KIND_QUERY, 0, 0, 0));
        queue_item(make_item(knn_pkg::KIND_QUERY, 17, 9, 1));
        wait_quiet();

        // fewer entries than slots
        write_entries_in_use(2);
        queue_item(make_item(knn_pkg::KIND_QUERY, 0, 0, 32767));
        queue_item(make_item(knn_pkg::KIND_QUERY, 0, 0, -32768));
        wait_quiet();
        write_entries_in_use(1);
        queue_item(make_item(knn_pkg::KIND_QUERY, 0, 0, 100));
        wait_quiet();

        // fill the whole store, then oversized setting saturates to the store
        write_entries_in_use(511);
        calm = 1'b1;
        for (int e = 0; e < STORE_DEPTH; e++)
        begin
            cfg = rand_label();
            queue_item(make_item(knn_pkg::KIND_LOAD, e, cfg, 1));
        end
        for (int i = 0; i < 6; i++)
            queue_item(make_item(knn_pkg::KIND_QUERY, $urandom_range(0, 255),
                                 rand_label(), 1));
        wait_quiet();
        calm = 1'b0;

        // random phases; mostly small searches, a few over the whole store
        phase = 0;
        while (items_queued < ITEM_GOAL)
        begin
            case ($urandom_range(0, 19))
                0:       cfg = 256;
                1:       cfg = $urandom_range(257, 511);
                2:       cfg = 0;
                default: cfg = $urandom_range(1, 48);
            endcase
            n_items = (cfg == 0 || cfg < 64) ? $urandom_range(30, 80) : 12;
            calm = (phase % 5 == 2);
            if (phase == 3)
            begin
                cfg = $urandom_range(1, 6);
                long_stall_go = 1'b1;   // receiver holds off, input backs up
            end
            write_entries_in_use(cfg);
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 99) < 55)
                    queue_item(make_item(knn_pkg::KIND_LOAD, $urandom_range(0, 255),
                                         rand_label(), 1));
                else
                    queue_item(make_item(knn_pkg::KIND_QUERY, $urandom_range(0, 255),
                                         $urandom_range(0, 15), 1));
            end
            wait_quiet();
            phase++;
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
